/* hdl/ifsf_pkg.sv */
package ifsf_pkg;

   localparam int HdrLen = 12;
   localparam int CountWidth = 4;

   typedef logic [7:0] byte_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [HdrLen-1:0][7:0] header_type;
   typedef logic [31:0] hash_type;
   typedef logic [2:0] format_type;

   localparam hash_type FnvBasis = 32'd2166136261;
   localparam hash_type FnvPrime = 32'd16777619;

   localparam format_type FmtUnknown = 3'd0;
   localparam format_type FmtPng = 3'd1;
   localparam format_type FmtJpeg = 3'd2;
   localparam format_type FmtBmp = 3'd3;
   localparam format_type FmtGif = 3'd4;
   localparam format_type FmtWebp = 3'd5;

   // signatures, first file byte in the top bits
   localparam logic [63:0] SigPng = 64'h89504E470D0A1A0A;
   localparam logic [23:0] SigJpeg = 24'hFFD8FF;
   localparam logic [15:0] SigBmp = 16'h424D;
   localparam logic [47:0] SigGif87 = 48'h474946383761;
   localparam logic [47:0] SigGif89 = 48'h474946383961;
   localparam logic [31:0] SigRiff = 32'h52494646;
   localparam logic [31:0] SigWebp = 32'h57454250;

   localparam count_type LenPng = 4'd8;
   localparam count_type LenJpeg = 4'd3;
   localparam count_type LenBmp = 4'd2;
   localparam count_type LenGif = 4'd6;
   localparam count_type LenFull = 4'd12;

endpackage

/* hdl/ifsf_classify.sv */
module ifsf_classify (
   input  ifsf_pkg::header_type header,
   input  ifsf_pkg::count_type  count,
   output ifsf_pkg::format_type format_code
);
   import ifsf_pkg::*;

   logic png_hit;
   logic jpeg_hit;
   logic bmp_hit;
   logic gif_hit;
   logic webp_hit;

   // length test first so unwritten entries never matter
   assign png_hit = (count >= LenPng) &&
      ({header[0], header[1], header[2], header[3],
        header[4], header[5], header[6], header[7]} == SigPng);
   assign jpeg_hit = (count >= LenJpeg) &&
      ({header[0], header[1], header[2]} == SigJpeg);
   assign bmp_hit = (count >= LenBmp) && ({header[0], header[1]} == SigBmp);
   assign gif_hit = (count >= LenGif) &&
      (({header[0], header[1], header[2], header[3], header[4], header[5]} == SigGif87) ||
       ({header[0], header[1], header[2], header[3], header[4], header[5]} == SigGif89));
   assign webp_hit = (count >= LenFull) &&
      ({header[0], header[1], header[2], header[3]} == SigRiff) &&
      ({header[8], header[9], header[10], header[11]} == SigWebp);

   always_comb begin
      priority if (png_hit) begin
         format_code = FmtPng;
      end else if (jpeg_hit) begin
         format_code = FmtJpeg;
      end else if (bmp_hit) begin
         format_code = FmtBmp;
      end else if (gif_hit) begin
         format_code = FmtGif;
      end else if (webp_hit) begin
         format_code = FmtWebp;
      end else begin
         format_code = FmtUnknown;
      end
   end

endmodule

/* hdl/image_format_sniff_and_fnv1a.sv */
// Image format sniffer with a running 32-bit FNV-1a hash. Bytes of one image
// arrive in file order on the req_ channel, one item per byte, with
// req_last_byte set on the final byte. Each byte is folded into the hash and
// the first twelve bytes are kept for signature matching; on the final byte a
// single item leaves on the rsp_ channel with the format code (unknown, PNG,
// JPEG, BMP, GIF, WebP) and the hash over the whole image, after which the
// block is ready for the next image with no gap. One byte is taken every
// clock cycle while no final byte is held back by a waiting result; the
// hash step (xor and a constant multiply) sits between the input register
// and the state and result registers. A final byte passes the input register
// and then the result register, which drives the rsp_ ports. A result waiting
// under rsp_stall only holds back a later final byte; ordinary bytes flow past it.
module image_format_sniff_and_fnv1a (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ifsf_pkg::byte_type    req_data_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ifsf_pkg::format_type  rsp_format_code,
   output ifsf_pkg::hash_type    rsp_hash_value
);
   import ifsf_pkg::*;

   // input register
   logic       in_valid_ff;
   byte_type   in_byte_ff;
   logic       in_last_ff;

   // per-image state
   hash_type   hash_ff;
   hash_type   hash_in;
   count_type  count_ff;
   count_type  count_in;
   header_type header_ff;
   header_type header_in;

   // result register
   logic       rsp_valid_ff;
   format_type rsp_format_ff;
   hash_type   rsp_hash_ff;

   format_type format_code;
   logic       advance;

   // a final byte may only move on once the result slot is free or being taken
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // fnv-1a step
   assign hash_in = 32'((hash_ff ^ {24'd0, in_byte_ff}) * FnvPrime);

   // header as it stands with the current byte included
   always_comb begin
      for (int i = 0; i < HdrLen; i++) begin
         header_in[i] = (count_ff == CountWidth'(i)) ? in_byte_ff : header_ff[i];
      end
      count_in = (count_ff < LenFull) ? count_ff + count_type'(1) : count_ff;
   end

   ifsf_classify u_classify (
      .header      (header_in),
      .count       (count_in),
      .format_code (format_code)
   );

   // control and state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hash_ff      <= FnvBasis;
         count_ff     <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            hash_ff  <= in_last_ff ? FnvBasis : hash_in;
            count_ff <= in_last_ff ? '0 : count_in;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         header_ff <= header_in;
      end
      if (advance && in_last_ff) begin
         rsp_format_ff <= format_code;
         rsp_hash_ff   <= hash_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_format_code = rsp_format_ff;
   assign rsp_hash_value  = rsp_hash_ff;

`ifndef SYNTHESIS
   // a final byte that moves on always produces a result next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("final byte did not produce a result");

   // per-image state returns to its start after each image
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (count_ff == '0 && hash_ff == FnvBasis))
      else $error("per-image state not cleared");

   // the byte count never passes the header length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LenFull)
      else $error("byte count past header length");

   // a waiting result is never overwritten
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_hash_ff)))
      else $error("waiting result lost");
`endif

endmodule
